[hw/rtl/first_fit_page_sector_allocator_core_defines.svh]
// Assertion macros for the sector allocator core.
`ifndef FIRST_FIT_PAGE_SECTOR_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_PAGE_SECTOR_ALLOCATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define FFPSA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ffpsa assertion failed");
`define FFPSA_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ffpsa reset assertion failed");
`else
`define FFPSA_ASSERT(lbl, clk, rstn, prop)
`define FFPSA_ASSERT_NR(lbl, clk, prop)
`endif

`endif

[hw/rtl/ffpsa_pkg.sv]
// Types and constants shared by the sector allocator modules.
package ffpsa_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned PageW   = 17;
  localparam int unsigned HdrW    = 7;
  localparam int unsigned ApbAw   = 4;
  localparam int unsigned ApbDw   = 32;
  localparam int unsigned DivRemW = 17;

  localparam logic [AddrW-1:0] HEAP_BASE_RST   = 32'h0001_0001;
  localparam logic [PageW-1:0] PAGE_BYTES_RST  = 17'h0_0200;
  localparam logic [HdrW-1:0]  HEADER_SIZE_RST = 7'd12;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_HEAP_BASE   = 2'd0,
    REG_PAGE_BYTES  = 2'd1,
    REG_HEADER_SIZE = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_LAST_RD,
    S_LAST_MUL,
    S_APPEND,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] request_size;
    logic [AddrW-1:0] release_addr;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] data_addr;
    logic             reused;
    status_e          status;
  } rsp_t;

  typedef struct packed {
    logic [AddrW-1:0] heap_base;
    logic [PageW-1:0] page_bytes;
    logic [HdrW-1:0]  header_size;
  } cfg_t;

  typedef struct packed {
    logic req_load;
    logic div_step;
    logic scan_run;
    logic hit_take;
    logic miss_take;
    logic last_rd;
    logic last_mul;
    logic append;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic hit;
    logic exhausted;
    logic is_free;
    logic full;
  } sts_t;

endpackage

[hw/rtl/ffpsa_stream_if.sv]
// Valid/ready stream channel carrying one payload per transfer.
interface ffpsa_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/first_fit_page_sector_allocator_core.sv]
// First-fit page sector allocator: top level.
//
// Requests arrive on req_i (op, request_size, release_addr) and one result
// per request leaves on rsp_o (data_addr, reused, status); each moves by a
// valid/ready transfer. heap_base, page_bytes and header_size are written
// over the APB port at byte addresses 0, 4 and 8; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// One request is worked at a time. An allocate runs a restoring divider
// for the page count, then walks the sector table one entry per cycle
// through its registered-read memory; when no free sector fits and the
// table is not full, the last entry is read, the end of its pages is
// computed and a new sector is appended. A free skips the divider.
// The result waits in an output register; req_i is ready again as soon as
// the result is handed to it, even while rsp_o is stalled. A stalled rsp_o
// holds the next finished result in the sequencer until the register frees.
// Reset empties the table (fill count to zero) and restores the register
// defaults; the table memories need no clearing pass.
module first_fit_page_sector_allocator_core #(
  parameter int unsigned MAX_SECTORS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ffpsa_stream_if.sink                req_i,
  ffpsa_stream_if.source              rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffpsa_pkg::ApbAw-1:0] paddr,
  input  logic [ffpsa_pkg::ApbDw-1:0] pwdata,
  output logic [ffpsa_pkg::ApbDw-1:0] prdata,
  output logic                        pready
);

  ffpsa_pkg::cfg_t cfg;
  ffpsa_pkg::cmd_t cmd;
  ffpsa_pkg::sts_t sts;
  ffpsa_pkg::rsp_t rsp;
  logic            in_ready;
  logic            out_valid;

  ffpsa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ffpsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffpsa_dp #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i.payload),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp)
  );

  assign req_i.ready   = in_ready;
  assign rsp_o.valid   = out_valid;
  assign rsp_o.payload = rsp;

endmodule

[hw/rtl/ffpsa_cfg.sv]
// APB configuration registers of the sector allocator.
module ffpsa_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ffpsa_pkg::ApbAw-1:0] paddr,
  input  logic [ffpsa_pkg::ApbDw-1:0] pwdata,
  output logic [ffpsa_pkg::ApbDw-1:0] prdata,
  output logic                       pready,
  output ffpsa_pkg::cfg_t            cfg_o
);

  ffpsa_pkg::cfg_t  cfg_q, cfg_d;
  ffpsa_pkg::reg_e  reg_idx;
  logic             wr_en;

  assign reg_idx = ffpsa_pkg::reg_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        ffpsa_pkg::REG_HEAP_BASE:   cfg_d.heap_base   = pwdata;
        ffpsa_pkg::REG_PAGE_BYTES:  cfg_d.page_bytes  = pwdata[ffpsa_pkg::PageW-1:0];
        ffpsa_pkg::REG_HEADER_SIZE: cfg_d.header_size = pwdata[ffpsa_pkg::HdrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ffpsa_pkg::REG_HEAP_BASE:   prdata = cfg_q.heap_base;
      ffpsa_pkg::REG_PAGE_BYTES:  prdata = {15'b0, cfg_q.page_bytes};
      ffpsa_pkg::REG_HEADER_SIZE: prdata = {25'b0, cfg_q.header_size};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heap_base   <= ffpsa_pkg::HEAP_BASE_RST;
      cfg_q.page_bytes  <= ffpsa_pkg::PAGE_BYTES_RST;
      cfg_q.header_size <= ffpsa_pkg::HEADER_SIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[hw/rtl/ffpsa_ctrl.sv]
// Request sequencer of the sector allocator.
`include "first_fit_page_sector_allocator_core_defines.svh"

module ffpsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  ffpsa_pkg::sts_t sts_i,
  output ffpsa_pkg::cmd_t cmd_o
);

  ffpsa_pkg::state_e state_q, state_d;
  logic              out_vld_q, out_vld_d;

  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ffpsa_pkg::S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ffpsa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = ffpsa_pkg::S_DIV;
        end
      end
      ffpsa_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.is_free || sts_i.div_last) begin
          state_d = ffpsa_pkg::S_SCAN;
        end
      end
      ffpsa_pkg::S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.hit) begin
          cmd_o.hit_take = 1'b1;
          state_d        = ffpsa_pkg::S_DONE;
        end else if (sts_i.exhausted) begin
          if (sts_i.is_free || sts_i.full) begin
            cmd_o.miss_take = 1'b1;
            state_d         = ffpsa_pkg::S_DONE;
          end else begin
            state_d = ffpsa_pkg::S_LAST_RD;
          end
        end
      end
      ffpsa_pkg::S_LAST_RD: begin
        cmd_o.last_rd = 1'b1;
        state_d       = ffpsa_pkg::S_LAST_MUL;
      end
      ffpsa_pkg::S_LAST_MUL: begin
        cmd_o.last_mul = 1'b1;
        state_d        = ffpsa_pkg::S_APPEND;
      end
      ffpsa_pkg::S_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = ffpsa_pkg::S_DONE;
      end
      ffpsa_pkg::S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ffpsa_pkg::S_IDLE;
        end
      end
      default: state_d = ffpsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  `FFPSA_ASSERT_NR(a_reset_idle, clk_i, !rst_ni |=> (state_q == ffpsa_pkg::S_IDLE && !out_vld_q))
  `FFPSA_ASSERT(a_done_waits, clk_i, rst_ni, (state_q == ffpsa_pkg::S_DONE && out_vld_q && !out_ready_i) |=> (state_q == ffpsa_pkg::S_DONE))
  `FFPSA_ASSERT(a_free_skips_div, clk_i, rst_ni, (state_q == ffpsa_pkg::S_DIV && sts_i.is_free) |=> (state_q == ffpsa_pkg::S_SCAN))
  `FFPSA_ASSERT(a_hit_ends_scan, clk_i, rst_ni, (state_q == ffpsa_pkg::S_SCAN && sts_i.hit) |=> (state_q == ffpsa_pkg::S_DONE))
  `FFPSA_ASSERT(a_miss_appends, clk_i, rst_ni, (state_q == ffpsa_pkg::S_SCAN && !sts_i.hit && sts_i.exhausted && !sts_i.is_free && !sts_i.full) |=> (state_q == ffpsa_pkg::S_LAST_RD))

endmodule

[hw/rtl/ffpsa_dp.sv]
// Sector table, page divider and address datapath of the sector allocator.
module ffpsa_dp #(
  parameter int unsigned MAX_SECTORS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffpsa_pkg::cfg_t cfg_i,
  input  ffpsa_pkg::req_t req_i,
  input  ffpsa_pkg::cmd_t cmd_i,
  output ffpsa_pkg::sts_t sts_o,
  output ffpsa_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxW = $clog2(MAX_SECTORS);
  localparam int unsigned CntW = $clog2(MAX_SECTORS + 1);
  localparam int unsigned AW   = ffpsa_pkg::AddrW;
  localparam int unsigned RW   = ffpsa_pkg::DivRemW;

  logic [AW-1:0] hdr_mem  [MAX_SECTORS];
  logic [AW-1:0] pages_mem[MAX_SECTORS];
  logic          used_mem [MAX_SECTORS];

  ffpsa_pkg::op_e op_q;
  logic [AW-1:0]  rel_q;
  logic [RW-1:0]  rem_q, rem_d;
  logic [AW-1:0]  quo_q, quo_d;
  logic [4:0]     div_cnt_q;
  logic [AW-1:0]  need_q;
  logic [CntW-1:0] count_q, scan_q;
  logic           rd_vld_q;
  logic [IdxW-1:0] rd_idx_q, rd_addr, last_idx;
  logic [AW-1:0]  hdr_rd_q, pages_rd_q;
  logic           used_rd_q;
  logic [AW-1:0]  base_q, prod_q;
  ffpsa_pkg::rsp_t res_q, res_d, out_q;

  logic [RW-1:0]  ps;
  logic [RW:0]    trial;
  logic           ge;
  logic [AW-1:0]  hsz;
  logic [AW-1:0]  rd_data_addr;
  logic           match, hit, issue;
  logic [AW-1:0]  new_hdr;
  logic           used_we, used_wval;
  logic [IdxW-1:0] used_widx;

  assign hsz = {{(AW - ffpsa_pkg::HdrW){1'b0}}, cfg_i.header_size};
  assign ps  = (cfg_i.page_bytes == '0) ? RW'(1) : cfg_i.page_bytes;

  assign trial = {rem_q, quo_q[AW-1]};
  assign ge    = trial >= {1'b0, ps};
  assign rem_d = ge ? RW'(trial - {1'b0, ps}) : trial[RW-1:0];
  assign quo_d = {quo_q[AW-2:0], ge};

  assign rd_data_addr = hdr_rd_q + hsz;
  assign match = (op_q == ffpsa_pkg::OP_ALLOC) ? (!used_rd_q && (pages_rd_q >= need_q))
                                               : (rd_data_addr == rel_q);
  assign hit   = rd_vld_q && match;
  assign issue = cmd_i.scan_run && (scan_q < count_q) && !hit;

  assign last_idx = (count_q == '0) ? '0 : IdxW'(count_q - CntW'(1));
  assign rd_addr  = cmd_i.last_rd ? last_idx : scan_q[IdxW-1:0];

  assign new_hdr = (count_q == '0) ? cfg_i.heap_base : base_q + prod_q;

  assign sts_o.div_last  = &div_cnt_q;
  assign sts_o.hit       = hit;
  assign sts_o.exhausted = !rd_vld_q && (scan_q == count_q);
  assign sts_o.is_free   = (op_q == ffpsa_pkg::OP_FREE);
  assign sts_o.full      = (count_q == CntW'(MAX_SECTORS));

  assign rsp_o = out_q;

  assign used_we   = cmd_i.append || (cmd_i.hit_take);
  assign used_wval = cmd_i.append || (op_q == ffpsa_pkg::OP_ALLOC);
  assign used_widx = cmd_i.append ? count_q[IdxW-1:0] : rd_idx_q;

  always_comb begin
    res_d = res_q;
    if (cmd_i.hit_take) begin
      if (op_q == ffpsa_pkg::OP_ALLOC) begin
        res_d.data_addr = rd_data_addr;
        res_d.reused    = 1'b1;
      end else begin
        res_d.data_addr = '0;
        res_d.reused    = 1'b0;
      end
      res_d.status = ffpsa_pkg::ST_OK;
    end else if (cmd_i.miss_take) begin
      res_d.data_addr = '0;
      res_d.reused    = 1'b0;
      res_d.status    = (op_q == ffpsa_pkg::OP_FREE) ? ffpsa_pkg::ST_NOT_FOUND
                                                     : ffpsa_pkg::ST_FULL;
    end else if (cmd_i.append) begin
      res_d.data_addr = new_hdr + hsz;
      res_d.reused    = 1'b0;
      res_d.status    = ffpsa_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      hdr_mem[count_q[IdxW-1:0]]   <= new_hdr;
      pages_mem[count_q[IdxW-1:0]] <= need_q;
    end
    if (used_we) begin
      used_mem[used_widx] <= used_wval;
    end
    hdr_rd_q   <= hdr_mem[rd_addr];
    pages_rd_q <= pages_mem[rd_addr];
    used_rd_q  <= used_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      op_q  <= req_i.op;
      rel_q <= req_i.release_addr;
      rem_q <= '0;
      quo_q <= req_i.request_size;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      need_q <= quo_d + AW'(rem_d != '0);
    end
    if (issue) begin
      rd_idx_q <= scan_q[IdxW-1:0];
    end
    if (cmd_i.last_mul) begin
      base_q <= rd_data_addr;
      prod_q <= pages_rd_q * AW'(cfg_i.page_bytes);
    end
    res_q <= res_d;
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      scan_q    <= '0;
      rd_vld_q  <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.req_load) begin
        scan_q    <= '0;
        div_cnt_q <= '0;
      end else begin
        if (issue) begin
          scan_q <= scan_q + CntW'(1);
        end
        if (cmd_i.div_step) begin
          div_cnt_q <= div_cnt_q + 5'd1;
        end
      end
      rd_vld_q <= issue;
      if (cmd_i.append) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the first-fit page sector allocator core.
module tb;

  localparam int unsigned SECTORS        = 64;
  localparam int unsigned PHASE_ITEMS    = 216;
  localparam int unsigned CHOKE_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES   = 120;
  localparam int unsigned TIMEOUT_CYCLES = 600000;

  typedef struct {
    bit                 is_cfg;
    ffpsa_pkg::reg_e    idx;
    logic [31:0]        value;
    ffpsa_pkg::req_t    req;
    bit                 typed;
    ffpsa_pkg::rsp_t    want;
  } step_t;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ffpsa_pkg::ApbAw-1:0] paddr;
  logic [ffpsa_pkg::ApbDw-1:0] pwdata;
  logic [ffpsa_pkg::ApbDw-1:0] prdata;
  logic                        pready;

  ffpsa_stream_if #(.payload_t(ffpsa_pkg::req_t)) req_if ();
  ffpsa_stream_if #(.payload_t(ffpsa_pkg::rsp_t)) rsp_if ();

  first_fit_page_sector_allocator_core #(
    .MAX_SECTORS(SECTORS)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  logic [31:0]                sec_hdr   [SECTORS];
  logic [31:0]                sec_pages [SECTORS];
  bit                         sec_used  [SECTORS];
  int unsigned                sec_count     = 0;
  logic [31:0]                heap_base_q   = ffpsa_pkg::HEAP_BASE_RST;
  logic [ffpsa_pkg::PageW-1:0] page_bytes_q = ffpsa_pkg::PAGE_BYTES_RST;
  logic [ffpsa_pkg::HdrW-1:0] header_size_q = ffpsa_pkg::HEADER_SIZE_RST;

  ffpsa_pkg::rsp_t pending_grants[$];
  int unsigned     mismatches    = 0;
  bit              steady        = 1'b0;
  bit              choke_request = 1'b0;
  step_t           script[$];

  function automatic ffpsa_pkg::rsp_t next_grant(ffpsa_pkg::req_t r);
    logic [31:0]     ps;
    logic [31:0]     need;
    logic [31:0]     hdr;
    bit              hit;
    int              i;
    ffpsa_pkg::rsp_t res;
    res = '0;
    res.status = ffpsa_pkg::ST_OK;
    hit = 1'b0;
    if (r.op == ffpsa_pkg::OP_ALLOC) begin
      ps = (page_bytes_q == '0) ? 32'd1 : 32'(page_bytes_q);
      need = r.request_size / ps;
      if (r.request_size % ps != 0) need = need + 32'd1;
      for (i = 0; i < int'(sec_count) && !hit; i++) begin
        if (!sec_used[i] && sec_pages[i] >= need) begin
          sec_used[i] = 1'b1;
          res.data_addr = sec_hdr[i] + 32'(header_size_q);
          res.reused = 1'b1;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (sec_count >= SECTORS) begin
          res.status = ffpsa_pkg::ST_FULL;
        end else begin
          if (sec_count == 0) hdr = heap_base_q;
          else hdr = sec_hdr[sec_count-1] + 32'(header_size_q)
                     + sec_pages[sec_count-1] * 32'(page_bytes_q);
          sec_hdr[sec_count]   = hdr;
          sec_pages[sec_count] = need;
          sec_used[sec_count]  = 1'b1;
          sec_count++;
          res.data_addr = hdr + 32'(header_size_q);
        end
      end
    end else begin
      res.status = ffpsa_pkg::ST_NOT_FOUND;
      for (i = 0; i < int'(sec_count) && !hit; i++) begin
        if (sec_hdr[i] + 32'(header_size_q) == r.release_addr) begin
          sec_used[i] = 1'b0;
          res.status = ffpsa_pkg::ST_OK;
          hit = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic int idle_gap();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic step_t req_step(ffpsa_pkg::op_e op, logic [31:0] size,
                                     logic [31:0] addr);
    step_t s;
    s.is_cfg = 1'b0;
    s.idx = ffpsa_pkg::REG_HEAP_BASE;
    s.value = '0;
    s.req.op = op;
    s.req.request_size = size;
    s.req.release_addr = addr;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t checked_step(ffpsa_pkg::op_e op, logic [31:0] size,
                                         logic [31:0] addr, logic [31:0] daddr,
                                         logic reused, ffpsa_pkg::status_e st);
    step_t s;
    s = req_step(op, size, addr);
    s.typed = 1'b1;
    s.want.data_addr = daddr;
    s.want.reused = reused;
    s.want.status = st;
    return s;
  endfunction

  function automatic step_t cfg_step(ffpsa_pkg::reg_e idx, logic [31:0] val);
    step_t s;
    s = req_step(ffpsa_pkg::OP_ALLOC, '0, '0);
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.value = val;
    return s;
  endfunction

  task automatic write_reg(ffpsa_pkg::reg_e idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      ffpsa_pkg::REG_HEAP_BASE:   heap_base_q = val;
      ffpsa_pkg::REG_PAGE_BYTES:  page_bytes_q = val[ffpsa_pkg::PageW-1:0];
      ffpsa_pkg::REG_HEADER_SIZE: header_size_q = val[ffpsa_pkg::HdrW-1:0];
      default: ;
    endcase
  endtask

  task automatic send(ffpsa_pkg::req_t r, bit typed, ffpsa_pkg::rsp_t want);
    int              gap;
    ffpsa_pkg::rsp_t grant;
    @(negedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.payload = r;
    do @(posedge clk); while (!req_if.ready);
    grant = next_grant(r);
    pending_grants.push_back(typed ? want : grant);
  endtask

  task automatic settle();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 4);
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    ffpsa_pkg::rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_grants.size() == 0) begin
        mismatches++;
        $display("%0t unexpected transfer: data_addr %h reused %b status %0d", $time,
                 rsp_if.payload.data_addr, rsp_if.payload.reused, rsp_if.payload.status);
      end else begin
        want = pending_grants.pop_front();
        if (rsp_if.payload.data_addr !== want.data_addr) begin
          mismatches++;
          $display("%0t data_addr: expected %h, got %h", $time,
                   want.data_addr, rsp_if.payload.data_addr);
        end
        if (rsp_if.payload.reused !== want.reused) begin
          mismatches++;
          $display("%0t reused: expected %b, got %b", $time,
                   want.reused, rsp_if.payload.reused);
        end
        if (rsp_if.payload.status !== want.status) begin
          mismatches++;
          $display("%0t status: expected %0d, got %0d", $time,
                   want.status, rsp_if.payload.status);
        end
      end
    end
  end

  initial begin
    int gap;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (choke_request) begin
        rsp_if.ready = 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk);
        choke_request = 1'b0;
      end
      gap = idle_gap();
      if (gap > 0) begin
        rsp_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready = 1'b1;
    end
  end

  initial begin
    int              ph;
    int              k;
    int unsigned     pick;
    ffpsa_pkg::req_t r;
    logic [31:0]     ps;
    logic [31:0]     base_v;
    logic [31:0]     page_v;
    logic [31:0]     hdr_v;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    script.push_back(checked_step(ffpsa_pkg::OP_FREE, 32'h0, 32'h0001_000D,
                                  32'h0, 1'b0, ffpsa_pkg::ST_NOT_FOUND));
    script.push_back(checked_step(ffpsa_pkg::OP_ALLOC, 32'h0, 32'h0,
                                  32'h0001_000D, 1'b0, ffpsa_pkg::ST_OK));
    script.push_back(req_step(ffpsa_pkg::OP_ALLOC, 32'd1, 32'h0));
    script.push_back(req_step(ffpsa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'h0));
    script.push_back(req_step(ffpsa_pkg::OP_ALLOC, 32'h200, 32'h0));
    script.push_back(checked_step(ffpsa_pkg::OP_FREE, 32'h0, 32'h0001_000D,
                                  32'h0, 1'b0, ffpsa_pkg::ST_OK));
    script.push_back(checked_step(ffpsa_pkg::OP_FREE, 32'h0, 32'h0001_000D,
                                  32'h0, 1'b0, ffpsa_pkg::ST_OK));
    script.push_back(checked_step(ffpsa_pkg::OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'h0, 1'b0, ffpsa_pkg::ST_NOT_FOUND));
    script.push_back(checked_step(ffpsa_pkg::OP_FREE, 32'h0, 32'h0,
                                  32'h0, 1'b0, ffpsa_pkg::ST_NOT_FOUND));
    script.push_back(checked_step(ffpsa_pkg::OP_ALLOC, 32'h0, 32'h0,
                                  32'h0001_000D, 1'b1, ffpsa_pkg::ST_OK));
    script.push_back(req_step(ffpsa_pkg::OP_FREE, 32'h0, 32'h0001_0225));
    script.push_back(req_step(ffpsa_pkg::OP_ALLOC, 32'h201, 32'h0));
    script.push_back(cfg_step(ffpsa_pkg::REG_PAGE_BYTES, 32'h0001_0000));
    script.push_back(req_step(ffpsa_pkg::OP_ALLOC, 32'h0001_0001, 32'h0));
    script.push_back(cfg_step(ffpsa_pkg::REG_PAGE_BYTES, 32'd1));
    script.push_back(cfg_step(ffpsa_pkg::REG_HEADER_SIZE, 32'd64));
    script.push_back(cfg_step(ffpsa_pkg::REG_HEAP_BASE, 32'hFFFF_FFFF));
    // two sectors that wrap onto the same data address
    script.push_back(req_step(ffpsa_pkg::OP_ALLOC, 32'hFFFF_FFC0, 32'h0));
    script.push_back(req_step(ffpsa_pkg::OP_ALLOC, 32'h0, 32'h0));
    script.push_back(req_step(ffpsa_pkg::OP_FREE, 32'h0, 32'h0002_02B3));
    script.push_back(req_step(ffpsa_pkg::OP_ALLOC, 32'd1, 32'h0));
    script.push_back(cfg_step(ffpsa_pkg::REG_PAGE_BYTES, 32'h0));
    script.push_back(req_step(ffpsa_pkg::OP_ALLOC, 32'd5, 32'h0));
    script.push_back(req_step(ffpsa_pkg::OP_FREE, 32'h0, 32'h0002_02F3));
    script.push_back(req_step(ffpsa_pkg::OP_ALLOC, 32'd3, 32'hFFFF_FFFF));

    foreach (script[n]) begin
      if (script[n].is_cfg) begin
        settle();
        write_reg(script[n].idx, script[n].value);
      end else begin
        send(script[n].req, script[n].typed, script[n].want);
      end
    end

    for (ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: begin
          base_v = 32'h0;
          page_v = 32'd1;
          hdr_v = 32'd1;
        end
        1: begin
          base_v = 32'hFFFF_FFFF;
          page_v = 32'h0001_0000;
          hdr_v = 32'd64;
        end
        2: begin
          base_v = $urandom;
          page_v = 32'd0;
          hdr_v = $urandom_range(1, 64);
        end
        3: begin
          base_v = $urandom;
          page_v = $urandom_range(1, 65536);
          hdr_v = $urandom_range(1, 64);
        end
        default: begin
          base_v = ffpsa_pkg::HEAP_BASE_RST;
          page_v = 32'(ffpsa_pkg::PAGE_BYTES_RST);
          hdr_v = 32'(ffpsa_pkg::HEADER_SIZE_RST);
        end
      endcase
      write_reg(ffpsa_pkg::REG_HEAP_BASE, base_v);
      write_reg(ffpsa_pkg::REG_PAGE_BYTES, page_v);
      write_reg(ffpsa_pkg::REG_HEADER_SIZE, hdr_v);
      if (ph == 3) choke_request = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        steady = ((k / 40) % 4 == 3);
        pick = $urandom_range(0, 99);
        r.request_size = $urandom;
        r.release_addr = $urandom;
        ps = (page_bytes_q == '0) ? 32'd1 : 32'(page_bytes_q);
        if (pick < 55) begin
          r.op = ffpsa_pkg::OP_ALLOC;
          pick = $urandom_range(0, 99);
          if (pick < 30) r.request_size = $urandom_range(0, 4 * ps);
          else if (pick < 60) r.request_size = $urandom_range(0, 32'hFFFF);
          else if (pick < 70) r.request_size = 32'h0;
          else if (pick < 75) r.request_size = 32'hFFFF_FFFF;
        end else begin
          r.op = ffpsa_pkg::OP_FREE;
          pick = $urandom_range(0, 99);
          if (sec_count > 0 && pick < 85) begin
            r.release_addr = sec_hdr[$urandom_range(0, sec_count - 1)]
                             + 32'(header_size_q);
            if (pick >= 75) r.release_addr = r.release_addr + 32'($urandom_range(1, 3));
          end
        end
        send(r, 1'b0, '0);
      end
    end

    steady = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ffpsa_pkg.sv
hw/rtl/ffpsa_stream_if.sv
hw/rtl/ffpsa_cfg.sv
hw/rtl/ffpsa_ctrl.sv
hw/rtl/ffpsa_dp.sv
hw/rtl/first_fit_page_sector_allocator_core.sv
tb/tb.sv
